[rtl/ibc_pkg.sv]
`timescale 1ns / 1ps

package ibc_pkg;

	localparam int NUM_ICONS = 8;
	localparam int IDX_W     = (NUM_ICONS > 1) ? $clog2(NUM_ICONS) : 1;
	localparam int IMG_BITS  = 8;
	localparam int PAD_W     = (NUM_ICONS > IMG_BITS) ? NUM_ICONS : IMG_BITS;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ICONS - 1);

	localparam logic [2:0] FN_TICK = 3'd0;
	localparam logic [2:0] FN_RATE = 3'd1;
	localparam logic [2:0] FN_VIS  = 3'd2;
	localparam logic [2:0] FN_READ = 3'd3;
	localparam logic [2:0] FN_OFF  = 3'd4;

	localparam logic [2:0] RATE_OFF  = 3'd0;
	localparam logic [2:0] RATE_10HZ = 3'd1;
	localparam logic [2:0] RATE_5HZ  = 3'd2;
	localparam logic [2:0] RATE_2HZ  = 3'd3;
	localparam logic [2:0] RATE_1HZ  = 3'd4;

	localparam logic [1:0] VIS_CLR = 2'd0;
	localparam logic [1:0] VIS_SET = 2'd1;
	localparam logic [1:0] VIS_TOG = 2'd2;

	localparam logic [2:0] DIV2_LAST = 3'd4;
	localparam logic [3:0] DIV1_LAST = 4'd9;

	typedef struct packed {
		logic       saved;
		logic [2:0] prev;
		logic [2:0] rate;
	} entry_t;

	typedef struct packed {
		logic f5;
		logic f2;
		logic f1;
	} fire_t;

	typedef struct packed {
		entry_t e;
		logic   v;
	} icon_upd_t;

	function automatic logic rate_fires(logic [2:0] rate, fire_t f);
		logic r;
		case (rate)
			RATE_10HZ: r = 1'b1;
			RATE_5HZ:  r = f.f5;
			RATE_2HZ:  r = f.f2;
			RATE_1HZ:  r = f.f1;
			default:   r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic icon_upd_t tick_update(entry_t e, logic v, fire_t f);
		icon_upd_t u;
		u.e = e;
		u.v = v;
		if (e.prev != e.rate && e.prev == RATE_OFF) begin
			u.e.prev  = e.rate;
			u.e.saved = v;
		end else if (e.prev != e.rate && e.rate == RATE_OFF) begin
			u.e.prev = RATE_OFF;
			u.v      = e.saved;
		end
		if (rate_fires(e.rate, f)) begin
			u.v = ~u.v;
		end
		return u;
	endfunction

endpackage

[rtl/ibc_dividers.sv]
`timescale 1ns / 1ps

module ibc_dividers (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	output ibc_pkg::fire_t fire
);

	logic       div5_q;
	logic [2:0] div2_q;
	logic [3:0] div1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div5_q <= 1'b0;
			div2_q <= 3'd0;
			div1_q <= 4'd0;
		end else if (advance) begin
			div5_q <= ~div5_q;
			div2_q <= (div2_q == ibc_pkg::DIV2_LAST) ? 3'd0 : div2_q + 3'd1;
			div1_q <= (div1_q == ibc_pkg::DIV1_LAST) ? 4'd0 : div1_q + 4'd1;
		end
	end

	assign fire.f5 = (div5_q == 1'b0);
	assign fire.f2 = (div2_q == 3'd0);
	assign fire.f1 = (div1_q == 4'd0);

endmodule

[rtl/ibc_state_mem.sv]
`timescale 1ns / 1ps

module ibc_state_mem (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [ibc_pkg::IDX_W-1:0] rd_addr,
	output ibc_pkg::entry_t           rd_data,
	input  logic                      wr_en,
	input  logic [ibc_pkg::IDX_W-1:0] wr_addr,
	input  ibc_pkg::entry_t           wr_data,
	input  logic                      clr_all
);

	ibc_pkg::entry_t                mem [ibc_pkg::NUM_ICONS];
	logic [ibc_pkg::NUM_ICONS-1:0]  valid_q;
	ibc_pkg::entry_t                data_q;
	logic                           ok_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		data_q <= mem[rd_addr];
	end

	// an entry not written since reset or all-off reads with rate and prev off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ok_q    <= 1'b0;
		end else begin
			ok_q <= valid_q[rd_addr];
			if (clr_all) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_comb begin
		rd_data = data_q;
		if (!ok_q) begin
			rd_data.prev = ibc_pkg::RATE_OFF;
			rd_data.rate = ibc_pkg::RATE_OFF;
		end
	end

endmodule

[rtl/icon_blink_controller.sv]
`timescale 1ns / 1ps
// Results: set-visibility, read, all-off and unused codes register their result in the
// cycle after the transfer; set-rate first passes through ST_RATE; a tick first walks ST_SWEEP.
// Throughput: one item at a time; the next transfer is taken once the block is idle and the
// output can take a result; a tick walks the state memory one entry per cycle (read-modify-write).
// Reset (arst_n, async): all icons invisible and blink off, dividers at zero,
// no result pending. No clearing pass; entry valid bits take its place.

module icon_blink_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // func[2:0], icon[5:3], blink_rate[8:6],
	                              // visibility_value[10:9], zero [15:11]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // display_image[7:0], read_visible[8], zero [15:9]
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SWEEP = 3'b010,
		ST_RATE  = 3'b100
	} state_t;

	state_t                        state_q;
	logic [ibc_pkg::IDX_W-1:0]     idx_q;
	logic [ibc_pkg::IDX_W-1:0]     icon_q;
	logic [2:0]                    rate_q;
	logic [ibc_pkg::NUM_ICONS-1:0] vis_q;
	logic                          out_vld_q;
	logic [7:0]                    out_img_q;
	logic                          out_rd_q;

	logic [2:0]                    in_func;
	logic [2:0]                    in_icon;
	logic [2:0]                    in_rate;
	logic [1:0]                    in_vis;
	logic                          acc;
	logic                          icon_ok;
	logic [ibc_pkg::IDX_W-1:0]     in_idx;

	state_t                        state_d;
	logic [ibc_pkg::IDX_W-1:0]     rd_addr;
	logic                          wr_en;
	logic [ibc_pkg::IDX_W-1:0]     wr_addr;
	ibc_pkg::entry_t               wr_data;
	ibc_pkg::entry_t               rd_data;
	logic                          clr_all;
	logic                          advance;
	ibc_pkg::fire_t                fire;
	ibc_pkg::icon_upd_t            upd;
	logic [ibc_pkg::NUM_ICONS-1:0] vis_d;
	logic [ibc_pkg::PAD_W-1:0]     vis_pad;
	logic                          out_load;
	logic                          rd_d;

	assign in_func  = s_tdata[2:0];
	assign in_icon  = s_tdata[5:3];
	assign in_rate  = s_tdata[8:6];
	assign in_vis   = s_tdata[10:9];
	assign s_tready = (state_q == ST_IDLE) && (!out_vld_q || m_tready);
	assign acc      = s_tvalid && s_tready;
	assign icon_ok  = (32'(in_icon) < 32'(ibc_pkg::NUM_ICONS));
	assign in_idx   = icon_ok ? ibc_pkg::IDX_W'(in_icon) : '0;

	ibc_dividers u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.fire    (fire)
	);

	ibc_state_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.clr_all (clr_all)
	);

	assign upd = ibc_pkg::tick_update(rd_data, vis_q[idx_q], fire);

	always_comb begin
		state_d  = state_q;
		rd_addr  = in_idx;
		wr_en    = 1'b0;
		wr_addr  = idx_q;
		wr_data  = upd.e;
		clr_all  = 1'b0;
		advance  = 1'b0;
		vis_d    = vis_q;
		out_load = 1'b0;
		rd_d     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (in_func)
						ibc_pkg::FN_TICK: begin
							advance = 1'b1;
							rd_addr = '0;
							state_d = ST_SWEEP;
						end
						ibc_pkg::FN_RATE: begin
							if (icon_ok && in_rate <= ibc_pkg::RATE_1HZ) begin
								state_d = ST_RATE;
							end else begin
								out_load = 1'b1;
							end
						end
						ibc_pkg::FN_VIS: begin
							out_load = 1'b1;
							if (icon_ok) begin
								case (in_vis)
									ibc_pkg::VIS_CLR: vis_d[in_idx] = 1'b0;
									ibc_pkg::VIS_SET: vis_d[in_idx] = 1'b1;
									ibc_pkg::VIS_TOG: vis_d[in_idx] = ~vis_q[in_idx];
									default:          vis_d[in_idx] = vis_q[in_idx];
								endcase
							end
						end
						ibc_pkg::FN_READ: begin
							out_load = 1'b1;
							rd_d     = icon_ok && vis_q[in_idx];
						end
						ibc_pkg::FN_OFF: begin
							out_load = 1'b1;
							clr_all  = 1'b1;
							vis_d    = '0;
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			ST_SWEEP: begin
				// read the next entry while writing back the current one
				rd_addr       = (idx_q == ibc_pkg::LAST_IDX) ? '0 : idx_q + 1'b1;
				wr_en         = 1'b1;
				vis_d[idx_q]  = upd.v;
				if (idx_q == ibc_pkg::LAST_IDX) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_RATE: begin
				wr_en        = 1'b1;
				wr_addr      = icon_q;
				wr_data      = rd_data;
				wr_data.rate = rate_q;
				out_load     = 1'b1;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign vis_pad = ibc_pkg::PAD_W'(vis_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			vis_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vis_q   <= vis_d;
			if (state_q == ST_SWEEP) begin
				idx_q <= (idx_q == ibc_pkg::LAST_IDX) ? '0 : idx_q + 1'b1;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			icon_q <= in_idx;
			rate_q <= in_rate;
		end
		if (out_load) begin
			out_img_q <= vis_pad[ibc_pkg::IMG_BITS-1:0];
			out_rd_q  <= rd_d;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'b0, out_rd_q, out_img_q};

	a_tick_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_func == ibc_pkg::FN_TICK) |=> (state_q == ST_SWEEP))
		else $error("tick transfer did not start a sweep");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q != ST_IDLE))
		else $error("state memory written while idle");

	a_sweep_ends_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && out_load) |-> (idx_q == ibc_pkg::LAST_IDX))
		else $error("sweep result before last icon");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_vld_q || m_tready))
		else $error("result overwrote a pending transfer");

endmodule
